// ----- hdl/eufr_pkg.sv -----
package eufr_pkg;

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// largest payload the back end will ever take
	localparam logic [10:0] MAX_PAYLOAD = 11'd1024;

	// result kinds on the master side tuser
	typedef enum logic [1:0] {
		KIND_DATA     = 2'd0,
		KIND_ACCEPT   = 2'd1,
		KIND_MISMATCH = 2'd2,
		KIND_ABANDON  = 2'd3
	} kind_t;

	// one classified byte, front to back
	typedef struct packed {
		logic       is_start;
		logic       is_esc;
		logic [7:0] raw;
		logic [7:0] flipped;
	} tok_t;

endpackage

// ----- hdl/eufr_front.sv -----
module eufr_front import eufr_pkg::*; (
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,
	input  logic [7:0] start_marker,
	input  logic [7:0] escape_marker,
	input  logic [7:0] flip_mask,
	input  logic       q_full,
	output logic       push,
	output tok_t       push_tok
);

	// take a beat whenever the queue has room
	assign s_tready = !q_full;
	assign push     = s_tvalid && !q_full;

	// marker compares and the escaped value, ready for the back end
	always_comb begin
		push_tok.is_start = (s_tdata == start_marker);
		push_tok.is_esc   = (s_tdata == escape_marker);
		push_tok.raw      = s_tdata;
		push_tok.flipped  = s_tdata ^ flip_mask;
	end

endmodule

// ----- hdl/eufr_queue.sv -----
module eufr_queue import eufr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  tok_t push_tok,
	input  logic pop,
	output logic full,
	output logic not_empty,
	output tok_t head_tok
);

	tok_t                slot_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	assign full      = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head_tok  = slot_q[rd_ptr_q];

	// storage, no reset needed
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_tok;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QUEUE_AW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QUEUE_AW+1)'(1);
			end
		end
	end

endmodule

// ----- hdl/eufr_back.sv -----
module eufr_back import eufr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        tok_valid,
	input  tok_t        tok,
	output logic        pop,
	input  logic [10:0] payload_limit,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,
	output logic [1:0]  m_tuser
);

	// crc-16-ccitt, one byte, msb first
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

	// frame state
	logic        in_frame_q, in_frame_n;
	logic        esc_q, esc_n;
	logic [10:0] cnt_q, cnt_n;
	logic [15:0] op_q, op_n;
	logic [15:0] len_q, len_n;
	logic [15:0] crc_q, crc_n;
	logic [7:0]  lo_q, lo_n;

	// output register
	logic        m_valid_q;
	kind_t       kind_q;
	logic [15:0] out_op_q;
	logic [10:0] out_len_q;
	logic [7:0]  out_data_q;
	logic [9:0]  out_idx_q;

	logic        res_v;
	kind_t       res_kind;
	logic [7:0]  res_data;
	logic [9:0]  res_idx;
	logic        use_cur;
	logic [7:0]  b;
	logic [10:0] limit;
	logic [11:0] pay_end;
	logic [15:0] len_chk;

	// a token moves on once the output slot is free or draining
	assign pop = tok_valid && (!m_valid_q || m_tready);

	assign limit   = (payload_limit > MAX_PAYLOAD) ? MAX_PAYLOAD : payload_limit;
	assign pay_end = 12'd4 + {1'b0, len_q[10:0]};
	assign b       = esc_q ? tok.flipped : tok.raw;
	assign len_chk = {b, len_q[7:0]};

	// frame sequencer
	always_comb begin
		in_frame_n = in_frame_q;
		esc_n      = esc_q;
		cnt_n      = cnt_q;
		op_n       = op_q;
		len_n      = len_q;
		crc_n      = crc_q;
		lo_n       = lo_q;
		res_v      = 1'b0;
		res_kind   = KIND_DATA;
		res_data   = '0;
		res_idx    = '0;
		use_cur    = 1'b0;
		if (pop) begin
			if (esc_q && (tok.is_start || tok.is_esc)) begin
				// bad escape drops the frame, nothing opens
				res_v      = in_frame_q;
				res_kind   = KIND_ABANDON;
				in_frame_n = 1'b0;
				esc_n      = 1'b0;
				cnt_n      = '0;
			end else if (tok.is_start) begin
				// restart: report the old frame, open a fresh one
				res_v      = in_frame_q;
				res_kind   = KIND_ABANDON;
				use_cur    = 1'b1;
				in_frame_n = 1'b1;
				esc_n      = 1'b0;
				cnt_n      = '0;
				op_n       = '0;
				len_n      = '0;
				crc_n      = 16'hFFFF;
				lo_n       = '0;
			end else if (!in_frame_q) begin
				res_v = 1'b0;
			end else if (tok.is_esc) begin
				esc_n = 1'b1;
			end else begin
				esc_n = 1'b0;
				if (cnt_q < 11'd4) begin
					// header bytes, little-endian
					crc_n = crc_byte(crc_q, b);
					cnt_n = cnt_q + 11'd1;
					case (cnt_q[1:0])
						2'd0:    op_n  = {op_q[15:8], b};
						2'd1:    op_n  = {b, op_q[7:0]};
						2'd2:    len_n = {len_q[15:8], b};
						2'd3:    len_n = len_chk;
						default: op_n  = op_q;
					endcase
					if (cnt_q == 11'd3 && len_chk > {5'd0, limit}) begin
						in_frame_n = 1'b0;
						res_v      = 1'b1;
						res_kind   = KIND_ABANDON;
					end
				end else if ({1'b0, cnt_q} < pay_end) begin
					// payload beat
					crc_n    = crc_byte(crc_q, b);
					res_v    = 1'b1;
					res_kind = KIND_DATA;
					res_data = b;
					res_idx  = 10'(cnt_q - 11'd4);
					cnt_n    = cnt_q + 11'd1;
				end else if ({1'b0, cnt_q} == pay_end) begin
					lo_n  = b;
					cnt_n = cnt_q + 11'd1;
				end else begin
					// crc high byte closes the frame
					in_frame_n = 1'b0;
					res_v      = 1'b1;
					res_kind   = ({b, lo_q} == crc_q) ? KIND_ACCEPT : KIND_MISMATCH;
				end
			end
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			esc_q      <= 1'b0;
			cnt_q      <= '0;
			op_q       <= '0;
			len_q      <= '0;
			crc_q      <= 16'hFFFF;
			lo_q       <= '0;
		end else begin
			in_frame_q <= in_frame_n;
			esc_q      <= esc_n;
			cnt_q      <= cnt_n;
			op_q       <= op_n;
			len_q      <= len_n;
			crc_q      <= crc_n;
			lo_q       <= lo_n;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (pop && res_v) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (pop && res_v) begin
			kind_q     <= res_kind;
			out_op_q   <= use_cur ? op_q : op_n;
			out_len_q  <= use_cur ? len_q[10:0] : len_n[10:0];
			out_data_q <= res_data;
			out_idx_q  <= res_idx;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = kind_q;
	assign m_tdata  = {3'd0, out_idx_q, out_data_q, out_len_q, out_op_q};

	// an escape is only ever pending inside a frame
	a_esc_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		esc_q |-> in_frame_q)
		else $error("escape pending outside a frame");

	// past the header the length has passed the limit check
	a_len_checked: assert property (@(posedge clk) disable iff (!arst_n)
		(in_frame_q && cnt_q > 11'd4) |-> (len_q <= {5'd0, MAX_PAYLOAD}))
		else $error("payload stage with oversize length");

	// the byte count never runs past payload plus header and crc
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= MAX_PAYLOAD + 11'd5)
		else $error("byte count out of range");

endmodule

// ----- hdl/escaped_uart_frame_receiver.sv -----
// channel   dir  signals                          contents
// s_axis    in   s_tvalid s_tready s_tdata[7:0]   rx_byte
// m_axis    out  m_tvalid m_tready m_tuser[1:0]   out_kind
//                m_tdata[47:0]                    opcode, length, data_byte, byte_index
// apb       in   psel penable pwrite paddr[3:0]   start, escape, flip, payload_limit
//
// one byte per cycle sustained while m_tready is high; a byte is classified
// in the cycle it is taken and its result, if any, leaves the queue and is
// registered into the output slot; a four-entry queue separates byte intake
// from the frame sequencer; a held result with m_tready low stalls the sequencer;
// intake stalls only once the queue is full
// arst_n clears frame state, queue and output valid; registers take their defaults
module escaped_uart_frame_receiver import eufr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [15:0] frame_opcode, [26:16] frame_length,
	                               // [34:27] data_byte, [44:35] byte_index
	output logic [1:0]  m_tuser,   // [1:0] out_kind
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam logic [1:0] REG_START  = 2'd0;
	localparam logic [1:0] REG_ESCAPE = 2'd1;
	localparam logic [1:0] REG_FLIP   = 2'd2;
	localparam logic [1:0] REG_LIMIT  = 2'd3;

	logic [7:0]  start_q;
	logic [7:0]  escape_q;
	logic [7:0]  flip_q;
	logic [10:0] limit_q;
	logic        cfg_wr;

	logic q_full;
	logic q_not_empty;
	logic push;
	logic pop;
	tok_t push_tok;
	tok_t head_tok;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= 8'd126;
			escape_q <= 8'd92;
			flip_q   <= 8'd64;
			limit_q  <= 11'd256;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_START:  start_q  <= pwdata[7:0];
				REG_ESCAPE: escape_q <= pwdata[7:0];
				REG_FLIP:   flip_q   <= pwdata[7:0];
				REG_LIMIT:  limit_q  <= pwdata[10:0];
				default:    start_q  <= start_q;
			endcase
		end
	end

	// register read back
	always_comb begin
		case (paddr[3:2])
			REG_START:  prdata = {24'd0, start_q};
			REG_ESCAPE: prdata = {24'd0, escape_q};
			REG_FLIP:   prdata = {24'd0, flip_q};
			REG_LIMIT:  prdata = {21'd0, limit_q};
			default:    prdata = '0;
		endcase
	end

	eufr_front u_front (
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.start_marker  (start_q),
		.escape_marker (escape_q),
		.flip_mask     (flip_q),
		.q_full        (q_full),
		.push          (push),
		.push_tok      (push_tok)
	);

	eufr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_tok  (push_tok),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head_tok  (head_tok)
	);

	eufr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.tok_valid     (q_not_empty),
		.tok           (head_tok),
		.pop           (pop),
		.payload_limit (limit_q),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser)
	);

endmodule
